@@ rtl/hbit_pkg.sv @@
// Package for the hashed bucket index table: xxHash32 constants, types, state enum.
// No dependencies.
package hbit_pkg;

    localparam logic [31:0] PR1  = 32'd2654435761;
    localparam logic [31:0] PR2  = 32'd2246822519;
    localparam logic [31:0] PR3  = 32'd3266489917;
    localparam logic [31:0] PR4  = 32'd668265263;
    localparam logic [31:0] PR5  = 32'd374761393;
    localparam logic [31:0] SEED = 32'd2018;

    localparam logic [7:0] MARK_EMPTY     = 8'd255;
    localparam logic [7:0] MARK_COLLISION = 8'd254;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_SEEK  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // multiplier operation codes
    typedef enum logic [1:0] {
        MOP_LANE,   // lane = rotl(lane + w*P2, 13) * P1
        MOP_WORD,   // h = rotl(h + w*P3, 17) * P4
        MOP_BYTE,   // h = rotl(h + b*P5, 11) * P1
        MOP_AVAL    // h = (h ^ h>>s) * k
    } mop_t;

    typedef enum logic [4:0] {
        S_CLR,      // clearing sweep
        S_IDLE,
        S_ABS_MUL,  // stripe round: multiply step for one lane
        S_ABS_ROT,  // stripe round: add, rotate, second multiply
        S_FIN_INIT,
        S_FIN_W1,
        S_FIN_W2,
        S_FIN_B1,
        S_FIN_B2,
        S_AV1,
        S_AV2,
        S_AV3,
        S_AV4,
        S_AV5,
        S_MOD,
        S_RD,
        S_UPD,
        S_OUT
    } state_t;

endpackage

@@ rtl/hashed_bucket_index_table.sv @@
// Top level of the hashed bucket index table: xxHash32 (seed 2018) over streamed key
// bytes, modulo by bucket count, byte table update. Uses hbit_pkg and hbit_mod.
//
// channel   dir  tdata fields (low first)                       tuser / tlast
// s_axis    in   key_byte[7:0] restart_pos[15:8]                tuser = op[1:0]
//                bucket_addr[25:16] (32 bits)                   tlast = key_last
// m_axis    out  bucket_value[7:0] bucket_id[17:8] (24 bits)    tuser = is_empty[0]
//                                                                       is_collision[1]
// cfg       in   bucket_count[10:0], written when cfg_we is high
//
// A key byte that completes a 16-byte stripe also runs a stripe round (4 lanes through
// the shared 32x32 multiplier, two products per lane).
// The last byte adds finalization (a setup step, two products per tail word or byte,
// then avalanche), a bit-serial remainder, and the table access.
// Clear and reset sweep the table one entry a cycle, and no beat is taken meanwhile.
// Reads go through S_RD and S_UPD to S_OUT. A new result waits in S_OUT while the output
// register still holds an unaccepted beat; s_axis_tready is high in S_IDLE only.
module hashed_bucket_index_table
    import hbit_pkg::*;
#(
    parameter int MAX_BUCKETS = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // key_byte, restart_pos, bucket_addr
    input  logic [1:0]  s_axis_tuser,   // op
    input  logic        s_axis_tlast,   // key_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // bucket_value, bucket_id
    output logic [1:0]  m_axis_tuser,   // is_empty, is_collision
    input  logic        cfg_we,
    input  logic [10:0] cfg_wdata
);

    localparam int AW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam logic [16:0] MAXB = 17'(MAX_BUCKETS);

    state_t state_reg, state_next;

    logic [10:0] bcount_reg;
    logic [31:0] lane_reg [4];
    logic [7:0]  stripe_reg [16];
    logic [31:0] klen_reg;
    logic [31:0] h_reg, t_reg;
    logic [1:0]  lane_idx_reg;
    logic [3:0]  pos_reg;
    logic [1:0]  op_reg;
    logic [7:0]  ri_reg;
    logic [AW-1:0] clr_reg;
    logic [7:0]  rd_reg;
    logic [10:0] idx_reg;
    logic [23:0] out_reg;
    logic [1:0]  out_user_reg;
    logic        out_valid_reg;
    logic        op_last_reg;
    logic        is_key_reg;   // S_RD path came from a key, not a read
    logic [7:0]  res_reg;
    logic        rd_in_range_reg;

    logic [7:0]  mem [MAX_BUCKETS];

    logic        take;
    logic        out_load;
    logic [1:0]  in_op;
    logic [7:0]  in_kb;
    logic [7:0]  in_ri;
    logic [9:0]  in_addr;
    logic [3:0]  wpos;
    logic        in_range;
    logic [7:0]  rd_upd;
    logic [7:0]  upd_val;
    logic        upd_we;
    logic [AW-1:0] mem_addr;

    assign in_op   = s_axis_tuser;
    assign in_kb   = s_axis_tdata[7:0];
    assign in_ri   = s_axis_tdata[15:8];
    assign in_addr = s_axis_tdata[25:16];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign take          = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;
    assign m_axis_tuser  = out_user_reg;

    // result register is free or drains at this edge
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || m_axis_tready);

    // shared multiplier, operands chosen by state
    logic [31:0] ma, mb, mp;
    assign mp = ma * mb;

    function automatic logic [31:0] word_at(input logic [3:0] p);
        word_at = {stripe_reg[p + 4'd3], stripe_reg[p + 4'd2],
                   stripe_reg[p + 4'd1], stripe_reg[p]};
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
        rotl = (x << r) | (x >> (32 - r));
    endfunction

    logic [31:0] rem_len;
    assign rem_len = {28'd0, klen_reg[3:0]};

    always_comb
    begin
        ma = t_reg;
        mb = PR1;
        unique case (state_reg)
            S_ABS_MUL:  begin ma = word_at({lane_idx_reg, 2'b00}); mb = PR2; end
            S_ABS_ROT:  begin ma = rotl(lane_reg[lane_idx_reg] + t_reg, 13); mb = PR1; end
            S_FIN_W1:   begin ma = word_at(pos_reg); mb = PR3; end
            S_FIN_W2:   begin ma = rotl(h_reg + t_reg, 17); mb = PR4; end
            S_FIN_B1:   begin ma = {24'd0, stripe_reg[pos_reg]}; mb = PR5; end
            S_FIN_B2:   begin ma = rotl(h_reg + t_reg, 11); mb = PR1; end
            S_AV1:      begin ma = h_reg ^ (h_reg >> 15); mb = PR2; end
            S_AV2:      begin ma = h_reg ^ (h_reg >> 13); mb = PR3; end
            default:    begin ma = t_reg; mb = PR1; end
        endcase
    end

    // remainder unit
    logic        mod_start, mod_done;
    logic [10:0] mod_rem, ncount;
    always_comb
    begin
        if (bcount_reg == 11'd0)
            ncount = 11'd1;
        else if ({6'd0, bcount_reg} > MAXB)
            ncount = MAXB[10:0];
        else
            ncount = bcount_reg;
    end
    assign mod_start = (state_reg == S_AV5);

    hbit_mod u_mod
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (h_reg),
        .divisor   (ncount),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLR:      if (32'(clr_reg) == MAX_BUCKETS - 1) state_next = S_IDLE;
            S_IDLE:
                if (take)
                begin
                    unique case (in_op)
                        OP_CLEAR: state_next = S_CLR;
                        OP_READ:  state_next = S_RD;
                        default:
                            if (klen_reg[3:0] == 4'd15) state_next = S_ABS_MUL;
                            else if (s_axis_tlast) state_next = S_FIN_INIT;
                    endcase
                end
            S_ABS_MUL:  state_next = S_ABS_ROT;
            S_ABS_ROT:
                if (lane_idx_reg != 2'd3) state_next = S_ABS_MUL;
                else if (op_last_reg) state_next = S_FIN_INIT;
                else state_next = S_IDLE;
            S_FIN_INIT:
                if (rem_len >= 32'd4) state_next = S_FIN_W1;
                else if (rem_len != 32'd0) state_next = S_FIN_B1;
                else state_next = S_AV1;
            S_FIN_W1:   state_next = S_FIN_W2;
            S_FIN_W2:
                if ({28'd0, pos_reg} + 32'd8 <= rem_len) state_next = S_FIN_W1;
                else if ({28'd0, pos_reg} + 32'd4 < rem_len) state_next = S_FIN_B1;
                else state_next = S_AV1;
            S_FIN_B1:   state_next = S_FIN_B2;
            S_FIN_B2:
                if ({28'd0, pos_reg} + 32'd1 < rem_len) state_next = S_FIN_B1;
                else state_next = S_AV1;
            S_AV1:      state_next = S_AV2;
            S_AV2:      state_next = S_AV3;
            S_AV3:      state_next = S_AV4;
            S_AV4:      state_next = S_AV5;
            S_AV5:      state_next = S_MOD;
            S_MOD:      if (mod_done) state_next = S_RD;
            S_RD:       state_next = S_UPD;
            S_UPD:      state_next = S_OUT;
            S_OUT:      if (out_load) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            bcount_reg    <= 11'd1;
            klen_reg      <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            lane_idx_reg  <= '0;
            lane_reg[0]   <= SEED + PR1 + PR2;
            lane_reg[1]   <= SEED + PR2;
            lane_reg[2]   <= SEED;
            lane_reg[3]   <= SEED - PR1;
            op_last_reg   <= 1'b0;
            is_key_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                bcount_reg <= cfg_wdata;
            if (out_load)
            begin
                out_reg       <= {6'd0, idx_reg[9:0], rd_upd};
                out_user_reg  <= {(rd_upd == MARK_COLLISION), (rd_upd == MARK_EMPTY)};
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tvalid && m_axis_tready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_CLR: clr_reg <= clr_reg + AW'(1);
                S_IDLE:
                    if (take)
                    begin
                        op_reg   <= in_op;
                        ri_reg   <= in_ri;
                        op_last_reg <= s_axis_tlast;
                        lane_idx_reg <= '0;
                        if (in_op == OP_CLEAR)
                        begin
                            clr_reg  <= '0;
                            klen_reg <= '0;
                            lane_reg[0] <= SEED + PR1 + PR2;
                            lane_reg[1] <= SEED + PR2;
                            lane_reg[2] <= SEED;
                            lane_reg[3] <= SEED - PR1;
                        end
                        else if (in_op == OP_READ)
                        begin
                            is_key_reg <= 1'b0;
                            idx_reg    <= {1'b0, in_addr};
                        end
                        else
                        begin
                            is_key_reg <= 1'b1;
                            stripe_reg[wpos] <= in_kb;
                            klen_reg <= klen_reg + 32'd1;
                        end
                    end
                S_ABS_MUL: t_reg <= mp;
                S_ABS_ROT:
                begin
                    lane_reg[lane_idx_reg] <= mp;
                    lane_idx_reg <= lane_idx_reg + 2'd1;
                end
                S_FIN_INIT:
                begin
                    pos_reg <= '0;
                    if (klen_reg >= 32'd16)
                        h_reg <= rotl(lane_reg[0], 1) + rotl(lane_reg[1], 7)
                               + rotl(lane_reg[2], 12) + rotl(lane_reg[3], 18) + klen_reg;
                    else
                        h_reg <= SEED + PR5 + klen_reg;
                end
                S_FIN_W1: t_reg <= mp;
                S_FIN_W2:
                begin
                    h_reg   <= mp;
                    pos_reg <= pos_reg + 4'd4;
                end
                S_FIN_B1: t_reg <= mp;
                S_FIN_B2:
                begin
                    h_reg   <= mp;
                    pos_reg <= pos_reg + 4'd1;
                end
                S_AV1: h_reg <= mp;
                S_AV2: h_reg <= mp;
                S_AV3: h_reg <= h_reg ^ (h_reg >> 16);
                S_AV4:
                begin
                    // key state back to reset
                    klen_reg    <= '0;
                    lane_reg[0] <= SEED + PR1 + PR2;
                    lane_reg[1] <= SEED + PR2;
                    lane_reg[2] <= SEED;
                    lane_reg[3] <= SEED - PR1;
                end
                S_AV5: ;
                S_MOD: if (mod_done) idx_reg <= mod_rem;
                default: ;
            endcase
        end
    end

    assign wpos = klen_reg[3:0];

    // table: one write and one registered read port
    assign in_range = ({6'd0, idx_reg} < MAXB);
    assign mem_addr = AW'(idx_reg);

    always_comb
    begin
        upd_val = rd_reg;
        upd_we  = 1'b0;
        if (is_key_reg && op_reg == OP_ADD)
        begin
            if (rd_reg == MARK_EMPTY)
            begin
                upd_val = ri_reg;
                upd_we  = 1'b1;
            end
            else if (rd_reg != MARK_COLLISION)
            begin
                upd_val = MARK_COLLISION;
                upd_we  = 1'b1;
            end
        end
    end

    assign rd_upd = res_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLR)
            mem[clr_reg] <= MARK_EMPTY;
        else if (state_reg == S_UPD && upd_we)
            mem[mem_addr] <= upd_val;
        if (state_reg == S_RD)
            rd_reg <= mem[mem_addr];
        if (state_reg == S_UPD)
            res_reg <= rd_in_range_reg ? upd_val : MARK_EMPTY;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_RD)
            rd_in_range_reg <= in_range;
    end

endmodule

@@ rtl/hbit_mod.sv @@
// Restoring remainder unit: 32-bit dividend modulo an 11-bit divisor, one bit a cycle.
// Depends on nothing beyond its ports.
module hbit_mod
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [10:0] divisor,
    output logic        done,
    output logic [10:0] remainder
);

    logic [31:0] quo_reg, quo_next;
    logic [11:0] rem_reg, rem_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [11:0] shifted;

    assign shifted   = {rem_reg[10:0], quo_reg[31]};
    assign remainder = rem_reg[10:0];

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done      = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[30:0], 1'b0};
            if (shifted >= {1'b0, divisor})
                rem_next = shifted - {1'b0, divisor};
            else
                rem_next = shifted;
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
                busy_next = 1'b0;
        end
        else if (cnt_reg == 6'd32)
        begin
            done     = 1'b1;
            cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

endmodule
